@@ rtl/bezier_perimeter_estimator_macros.svh @@
// assertion macros for the bezier perimeter estimator checker
// no dependencies; expects clk and rst in scope where used
`ifndef BEZIER_PERIMETER_ESTIMATOR_MACROS_SVH
`define BEZIER_PERIMETER_ESTIMATOR_MACROS_SVH

// implication in the same cycle, masked during reset
`define BPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, masked during reset
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication in the next cycle, active through reset
`define BPE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bpe_pkg.sv @@
// shared types and constants of the bezier perimeter estimator
// no dependencies
package bpe_pkg;

  localparam int SEG_W = 26;
  localparam int TOT_W = 40;
  localparam logic [SEG_W-1:0] SEG_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_QUAD    = 2'd1,
    KIND_CUBIC   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIFF,
    BK_SQUARE,
    BK_SUM,
    BK_ROOT,
    BK_ACC,
    BK_DONE
  } back_state_t;

  // decoded segment: which legs to measure and how to combine them
  typedef struct packed {
    logic       first;
    logic       halve;
    logic [2:0] n_legs;
    logic [1:0] n_net;
    logic [1:0] chord_end;
  } seg_ctrl_t;

endpackage

@@ rtl/bpe_front.sv @@
// front stage: accepts a segment word, decodes its kind into a leg plan
// depends on bpe_pkg
module bpe_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    first_of_shape,
  input  logic [1:0]              curve_kind,
  input  logic [8*COORD_BITS-1:0] pts_in,
  output logic                    push,
  input  logic                    q_ready,
  output bpe_pkg::seg_ctrl_t      ctrl,
  output logic [8*COORD_BITS-1:0] pts
);
  import bpe_pkg::*;

  logic      full;
  seg_ctrl_t dec;

  always_comb begin
    dec = '0;
    dec.first = first_of_shape;
    unique case (kind_t'(curve_kind))
      KIND_LINE: begin
        dec.n_legs = 3'd1;
        dec.n_net  = 2'd1;
      end
      KIND_QUAD: begin
        dec.halve     = 1'b1;
        dec.n_legs    = 3'd3;
        dec.n_net     = 2'd2;
        dec.chord_end = 2'd2;
      end
      KIND_CUBIC: begin
        dec.halve     = 1'b1;
        dec.n_legs    = 3'd4;
        dec.n_net     = 2'd3;
        dec.chord_end = 2'd3;
      end
      default: dec.n_legs = 3'd0;
    endcase
  end

  assign push     = full;
  assign in_ready = !full || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (q_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctrl <= dec;
      pts  <= pts_in;
    end
  end

endmodule

@@ rtl/bpe_queue.sv @@
// two-entry queue of decoded segments between front and back
// depends on bpe_pkg
module bpe_queue #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    push_ready,
  input  bpe_pkg::seg_ctrl_t      push_ctrl,
  input  logic [8*COORD_BITS-1:0] push_pts,
  output logic                    pop_valid,
  input  logic                    pop,
  output bpe_pkg::seg_ctrl_t      pop_ctrl,
  output logic [8*COORD_BITS-1:0] pop_pts
);
  import bpe_pkg::*;

  seg_ctrl_t               ctrl_mem [2];
  logic [8*COORD_BITS-1:0] pts_mem  [2];
  logic                    wr_ptr, rd_ptr;
  logic [1:0]              count;
  logic                    do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_ctrl   = ctrl_mem[rd_ptr];
  assign pop_pts    = pts_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctrl_mem[wr_ptr] <= push_ctrl;
      pts_mem[wr_ptr]  <= push_pts;
    end
  end

endmodule

@@ rtl/bpe_back.sv @@
// back end: per leg difference, squares, bit-serial square root, then
// the segment estimate, running total and output register; uses bpe_pkg
module bpe_back #(
  parameter int COORD_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     pop,
  input  bpe_pkg::seg_ctrl_t       q_ctrl,
  input  logic [8*COORD_BITS-1:0]  q_pts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [bpe_pkg::SEG_W-1:0] segment_length,
  output logic [bpe_pkg::TOT_W-1:0] total_length,
  output logic                     total_saturated
);
  import bpe_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int FS_W  = 2 * CB + 1;
  localparam int SQ_W  = (FS_W > 64) ? 64 : FS_W;
  localparam int RT_W  = (SQ_W + 1) / 2;
  localparam int OP_W  = 2 * RT_W;
  localparam int ACC_W = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  back_state_t state, state_next;
  seg_ctrl_t   ctrl;
  logic [8*CB-1:0] pts;
  logic [1:0]  leg;
  logic [CB-1:0] dx, dy;
  logic [2*CB-1:0] sqx, sqy;
  logic [OP_W-1:0] op;
  logic [RT_W+1:0] rem;
  logic [RT_W-1:0] root;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] acc;
  logic [TOT_W-1:0] total;

  // strobes from the output decode
  logic ld_item, ld_diff, ld_sq, ld_sum, ld_root, ld_acc, ld_out;

  logic signed [CB-1:0] px [4];
  logic signed [CB-1:0] py [4];
  logic [1:0]  ia, ib;
  logic signed [CB:0] ddx, ddy, mx, my;
  logic [FS_W-1:0] sum_full;
  logic [SQ_W-1:0] sq;
  logic [RT_W+1:0] rsh, trial;
  logic last_leg, out_free;
  logic [ACC_W-1:0] segr;
  logic [63:0] segw;
  logic [SEG_W-1:0] seg;
  logic [TOT_W-1:0] base, room, tot_next;

  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign px[i] = q_pts_sel(2 * i);
    assign py[i] = q_pts_sel(2 * i + 1);
  end

  function automatic logic [CB-1:0] q_pts_sel(input int k);
    q_pts_sel = pts[k*CB +: CB];
  endfunction

  // leg endpoints: net legs first, chord last
  always_comb begin
    if ({1'b0, leg} < {1'b0, ctrl.n_net}) begin
      ia = leg + 2'd1;
      ib = leg;
    end else begin
      ia = ctrl.chord_end;
      ib = 2'd0;
    end
  end

  assign ddx = {px[ia][CB-1], px[ia]} - {px[ib][CB-1], px[ib]};
  assign ddy = {py[ia][CB-1], py[ia]} - {py[ib][CB-1], py[ib]};
  assign mx  = ddx[CB] ? -ddx : ddx;
  assign my  = ddy[CB] ? -ddy : ddy;

  assign sum_full = {1'b0, sqx} + {1'b0, sqy};
  if (FS_W > 64) begin : g_sat
    assign sq = (|sum_full[FS_W-1:64]) ? '1 : sum_full[63:0];
  end else begin : g_nosat
    assign sq = sum_full;
  end

  // one root bit per cycle, restoring
  assign rsh   = {rem[RT_W-1:0], op[OP_W-1 -: 2]};
  assign trial = {root, 2'b01};

  assign last_leg = ({1'b0, leg} + 3'd1) == ctrl.n_legs;
  assign out_free = !out_valid || out_ready;

  assign segr = ctrl.halve ? (acc >> 1) : acc;
  assign segw = 64'(segr);
  assign seg  = (segw > 64'(SEG_MAX)) ? SEG_MAX : segw[SEG_W-1:0];
  assign base = ctrl.first ? '0 : total;
  assign room = TOT_MAX - base;
  assign tot_next = ({{(TOT_W-SEG_W){1'b0}}, seg} >= room) ? TOT_MAX
                  : base + {{(TOT_W-SEG_W){1'b0}}, seg};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid) state_next = (q_ctrl.n_legs == 3'd0) ? BK_DONE : BK_DIFF;
      BK_DIFF:   state_next = BK_SQUARE;
      BK_SQUARE: state_next = BK_SUM;
      BK_SUM:    state_next = BK_ROOT;
      BK_ROOT:   if (cnt == CNT_W'(RT_W - 1)) state_next = BK_ACC;
      BK_ACC:    state_next = last_leg ? BK_DONE : BK_DIFF;
      BK_DONE:   if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    ld_item = 1'b0;
    ld_diff = 1'b0;
    ld_sq   = 1'b0;
    ld_sum  = 1'b0;
    ld_root = 1'b0;
    ld_acc  = 1'b0;
    ld_out  = 1'b0;
    unique case (state)
      BK_IDLE:   ld_item = q_valid;
      BK_DIFF:   ld_diff = 1'b1;
      BK_SQUARE: ld_sq   = 1'b1;
      BK_SUM:    ld_sum  = 1'b1;
      BK_ROOT:   ld_root = 1'b1;
      BK_ACC:    ld_acc  = 1'b1;
      BK_DONE:   ld_out  = out_free;
      default:   ld_item = 1'b0;
    endcase
  end

  assign pop = ld_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      state <= state_next;
      if (ld_out) begin
        out_valid <= 1'b1;
        total     <= tot_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      ctrl <= q_ctrl;
      pts  <= q_pts;
      leg  <= 2'd0;
      acc  <= '0;
    end
    if (ld_diff) begin
      dx <= mx[CB-1:0];
      dy <= my[CB-1:0];
    end
    if (ld_sq) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
    end
    if (ld_sum) begin
      op   <= OP_W'(sq);
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end
    if (ld_root) begin
      op  <= op << 2;
      cnt <= cnt + CNT_W'(1);
      if (rsh >= trial) begin
        rem  <= rsh - trial;
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem  <= rsh;
        root <= {root[RT_W-2:0], 1'b0};
      end
    end
    if (ld_acc) begin
      acc <= acc + ACC_W'(root);
      leg <= leg + 2'd1;
    end
    if (ld_out) begin
      segment_length  <= seg;
      total_length    <= tot_next;
      total_saturated <= (tot_next == TOT_MAX);
    end
  end

endmodule

@@ rtl/bezier_perimeter_estimator.sv @@
// top level of the bezier perimeter estimator
// depends on bpe_pkg, bpe_front, bpe_queue, bpe_back
//
//  channel | handshake           | word
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_ready  | first_of_shape, curve_kind, 4 points
//  out     | out_valid, out_ready| segment_length, total_length, saturated
//
// each leg runs difference, square, sum, the root over R bits, then accumulate,
// R = root bits (25 at 24-bit coordinates), set by the single bit-serial square
// root unit shared by all legs; a line has one leg, a quadratic three, a cubic
// four; unknown kinds have no legs; front and queue hide the input acceptance
// reset clears the running total, the queue and both valid flags
// a stalled output only holds the back end once its next word is finished
module bezier_perimeter_estimator #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         first_of_shape,
  input  logic [1:0]                   curve_kind,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] pt1_x,
  input  logic signed [COORD_BITS-1:0] pt1_y,
  input  logic signed [COORD_BITS-1:0] pt2_x,
  input  logic signed [COORD_BITS-1:0] pt2_y,
  input  logic signed [COORD_BITS-1:0] pt3_x,
  input  logic signed [COORD_BITS-1:0] pt3_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpe_pkg::SEG_W-1:0]    segment_length,
  output logic [bpe_pkg::TOT_W-1:0]    total_length,
  output logic                         total_saturated
);
  import bpe_pkg::*;

  // points packed low to high: p0 x, p0 y, p1 x, ... p3 y
  logic [8*COORD_BITS-1:0] pts_in, f_pts, q_pts;
  seg_ctrl_t               f_ctrl, q_ctrl;
  logic                    f_push, q_ready, q_valid, b_pop;

  assign pts_in = {pt3_y, pt3_x, pt2_y, pt2_x, pt1_y, pt1_x, start_y, start_x};

  // accepts and decodes
  bpe_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .first_of_shape, .curve_kind,
    .pts_in, .push(f_push), .q_ready, .ctrl(f_ctrl), .pts(f_pts)
  );

  // lets front keep taking words while the back end is busy
  bpe_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk, .rst, .push(f_push), .push_ready(q_ready), .push_ctrl(f_ctrl),
    .push_pts(f_pts), .pop_valid(q_valid), .pop(b_pop), .pop_ctrl(q_ctrl),
    .pop_pts(q_pts)
  );

  // distances, estimate and running total
  bpe_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .q_valid, .pop(b_pop), .q_ctrl, .q_pts, .out_valid,
    .out_ready, .segment_length, .total_length, .total_saturated
  );

endmodule

@@ rtl/bpe_checker.sv @@
// port-level checks of the bezier perimeter estimator, bound to the top
// depends on bpe_pkg and bezier_perimeter_estimator_macros.svh
`include "bezier_perimeter_estimator_macros.svh"

module bpe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpe_pkg::SEG_W-1:0]    segment_length,
  input logic [bpe_pkg::TOT_W-1:0]    total_length,
  input logic                         total_saturated
);
  import bpe_pkg::*;

  `BPE_ASSERT_RST(a_rst_idle, rst, !out_valid, "output valid right after reset")
  `BPE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(total_length), "stalled word dropped or changed")
  `BPE_ASSERT_NOW(a_sat_flag, out_valid, total_saturated == (total_length == TOT_MAX), "saturation flag disagrees with total")
  `BPE_ASSERT_NOW(a_seg_in_total, out_valid, {{(TOT_W-SEG_W){1'b0}}, segment_length} <= total_length, "total below its own segment")

endmodule

bind bezier_perimeter_estimator bpe_checker u_bpe_checker (
  .clk, .rst, .out_valid, .out_ready, .segment_length, .total_length,
  .total_saturated
);

@@ tb/sv/testbench.sv @@
// self-checking testbench for the bezier perimeter estimator
// depends on bpe_pkg and the bezier_perimeter_estimator rtl
// words are predicted in-bench and compared field by field at the output
`timescale 1ns / 1ps

module testbench;
  import bpe_pkg::*;

  localparam int CW = 24;
  localparam int IDLE_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int LONG_HOLD = 400;    // receiver hold-off, longer than the queue can hide

  typedef struct {
    logic                 first;
    kind_t                kind;
    logic signed [CW-1:0] x [4];
    logic signed [CW-1:0] y [4];
    bit                   drain;     // wait for every result before offering this word
  } seg_word_t;

  typedef struct {
    logic [SEG_W-1:0] seg;
    logic [TOT_W-1:0] tot;
    logic             sat;
  } length_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic first_of_shape = 1'b0;
  logic [1:0] curve_kind = KIND_LINE;
  logic signed [CW-1:0] start_x = '0, start_y = '0, pt1_x = '0, pt1_y = '0;
  logic signed [CW-1:0] pt2_x = '0, pt2_y = '0, pt3_x = '0, pt3_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SEG_W-1:0] segment_length;
  logic [TOT_W-1:0] total_length;
  logic total_saturated;

  seg_word_t    pending_segs[$];
  length_word_t expected_lengths[$];
  seg_word_t    cur_seg;
  logic [TOT_W-1:0] running_total = '0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  bezier_perimeter_estimator #(.COORD_BITS(CW)) u_top (
    .clk, .rst, .in_valid, .in_ready, .first_of_shape, .curve_kind,
    .start_x, .start_y, .pt1_x, .pt1_y, .pt2_x, .pt2_y, .pt3_x, .pt3_y,
    .out_valid, .out_ready, .segment_length, .total_length, .total_saturated
  );

  // bit-by-bit floor square root
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // euclidean distance between two points, q.8 in, q.8 out
  function automatic longint unsigned leg_length(seg_word_t s, int a, int b);
    longint dx;
    longint dy;
    dx = longint'(s.x[a]) - longint'(s.x[b]);
    dy = longint'(s.y[a]) - longint'(s.y[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return floor_sqrt(longint'(dx * dx + dy * dy));
  endfunction

  // estimate one segment and advance the running total
  function automatic length_word_t estimate_segment(seg_word_t s);
    length_word_t r;
    longint unsigned est;
    longint unsigned room;
    est = 0;
    case (s.kind)
      KIND_LINE:  est = leg_length(s, 1, 0);
      KIND_QUAD:  est = (leg_length(s, 2, 0) + leg_length(s, 1, 0)
                        + leg_length(s, 2, 1)) >> 1;
      KIND_CUBIC: est = (leg_length(s, 3, 0) + leg_length(s, 1, 0)
                        + leg_length(s, 2, 1) + leg_length(s, 3, 2)) >> 1;
      default:    est = 0;
    endcase
    if (est > longint'(SEG_MAX)) est = 64'(SEG_MAX);
    if (s.first) running_total = '0;
    room = longint'(TOT_MAX) - longint'(running_total);
    if (est >= room) running_total = TOT_MAX;
    else running_total = TOT_W'(running_total + est);
    r.seg = est[SEG_W-1:0];
    r.tot = running_total;
    r.sat = (running_total == TOT_MAX);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch on word %0d: %s got %0d, expected %0d", words_checked, field, got, want);
  endtask

  // coordinates: full range, near the extremes, or small values near zero
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? CW'(24'sh7fffff - $urandom_range(0, 3))
                                     : CW'(24'sh800000 + $urandom_range(0, 3));
      1: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic seg_word_t make_seg(bit first, kind_t kind, bit drain);
    seg_word_t s;
    s.first = first;
    s.kind = kind;
    s.drain = drain;
    for (int i = 0; i < 4; i++) begin
      s.x[i] = pick_coord();
      s.y[i] = pick_coord();
    end
    return s;
  endfunction

  // stimulus: directed corners first, then a random mix of shapes
  initial begin
    seg_word_t s;
    s = make_seg(1'b1, KIND_LINE, 1'b0);
    s.x = '{default: 24'sd0}; s.y = '{default: 24'sd0};
    pending_segs.push_back(s);                             // zero-length line
    s.x[0] = 24'sh800000; s.y[0] = 24'sh800000;
    s.x[1] = 24'sh7fffff; s.y[1] = 24'sh7fffff;
    s.first = 1'b0;
    pending_segs.push_back(s);                             // longest line
    s.x[2] = 24'sh800000; s.y[2] = 24'sh7fffff;
    s.x[3] = 24'sh7fffff; s.y[3] = 24'sh800000;
    s.kind = KIND_QUAD;  pending_segs.push_back(s);        // quadratic at the corners
    s.kind = KIND_CUBIC; pending_segs.push_back(s);        // longest cubic net
    s.kind = KIND_UNKNOWN; pending_segs.push_back(s);      // unknown adds zero
    s.first = 1'b1; pending_segs.push_back(s);             // unknown still clears
    s.x = '{default: 24'sh123456}; s.y = '{default: -24'sd77};
    s.first = 1'b0; s.kind = KIND_CUBIC;
    pending_segs.push_back(s);                             // degenerate cubic
    s.x[1] = 24'sd256; s.kind = KIND_LINE;
    pending_segs.push_back(s);
    for (int i = 0; i < 12; i++)
      pending_segs.push_back(make_seg(i % 4 == 0, kind_t'(i % 4), 1'b0));
    for (int i = 0; i < 430; i++)
      pending_segs.push_back(make_seg($urandom_range(0, 9) == 0,
                                      kind_t'($urandom_range(0, 3)), i == 220));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_segs.size() == 0 && !in_valid && expected_lengths.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d segments sent, %0d lengths checked", words_sent, words_checked);
    $display("lines %0d, quadratics %0d, cubics %0d, unknown %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (mismatches == 0 && expected_lengths.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // driver: bursts and gaps, holds the word until accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_lengths.push_back(estimate_segment(cur_seg));
        kind_count[cur_seg.kind]++;
        words_sent++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_segs.size() == 0
                     || (pending_segs[0].drain && expected_lengths.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_seg = pending_segs.pop_front();
          first_of_shape <= cur_seg.first;
          curve_kind <= cur_seg.kind;
          start_x <= cur_seg.x[0]; start_y <= cur_seg.y[0];
          pt1_x <= cur_seg.x[1]; pt1_y <= cur_seg.y[1];
          pt2_x <= cur_seg.x[2]; pt2_y <= cur_seg.y[2];
          pt3_x <= cur_seg.x[3]; pt3_y <= cur_seg.y[3];
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
          end
        end
      end
    end
  end

  // monitor: checks each word, stalls on its own pattern
  always @(posedge clk) begin
    length_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_lengths.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_lengths.pop_front();
          if (segment_length !== want.seg) report_mismatch("segment_length", segment_length, want.seg);
          if (total_length !== want.tot) report_mismatch("total_length", total_length, want.tot);
          if (total_saturated !== want.sat) report_mismatch("total_saturated", total_saturated, want.sat);
        end
        words_checked++;
        if (words_checked == 60) hold_left = LONG_HOLD;   // long hold-off, input must back up
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (words_checked >= 150 && words_checked < 220) begin
        out_ready <= 1'b1;                                // stretch with no stalls
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
